@@ hw/rtl/mrbrb_pkg.sv @@
// ----------------------------------------------------------------------------
// mrbrb_pkg: shared types and constants of the multi-reader byte ring buffer
// Request and result records, front-to-back command record, operation codes.
// ----------------------------------------------------------------------------
package mrbrb_pkg;

  // default sizing
  localparam int STORE_DEPTH_DEF  = 1024;
  localparam int MAX_READ_RUN_DEF = 64;
  localparam int QUEUE_DEPTH      = 4;

  // fixed field widths
  localparam int OP_W     = 2;
  localparam int CURSOR_W = 32;
  localparam int BYTE_W   = 8;
  localparam int READ_W   = 7;
  localparam int LEVEL_W  = 10;

  // operation codes
  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [CURSOR_W-1:0] cursor;
    logic [BYTE_W-1:0]   write_byte;
    logic [READ_W-1:0]   read_length;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   read_byte;
    logic                last;
    logic                accepted;
    logic [READ_W-1:0]   byte_count;
    logic [LEVEL_W-1:0]  bytes_after;
    logic [LEVEL_W-1:0]  bytes_before;
    logic [CURSOR_W-1:0] write_position;
    logic [CURSOR_W-1:0] oldest_position;
    logic [LEVEL_W-1:0]  fill_level;
  } out_t;

  // per-item status, shared by every result of the item
  typedef struct packed {
    logic                accepted;
    logic [READ_W-1:0]   byte_count;
    logic [LEVEL_W-1:0]  bytes_after;
    logic [LEVEL_W-1:0]  bytes_before;
    logic [CURSOR_W-1:0] write_position;
    logic [CURSOR_W-1:0] oldest_position;
    logic [LEVEL_W-1:0]  fill_level;
  } info_t;

  // what the back end has to do with a command
  typedef enum logic [1:0] {
    KIND_READ,   // run of one or more store reads
    KIND_WRITE,  // one store write
    KIND_NOTE    // status result only
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [BYTE_W-1:0] write_byte;
    info_t             info;
  } cmd_t;

endpackage

@@ hw/rtl/multi_reader_byte_ring_buffer_unit.sv @@
// ----------------------------------------------------------------------------
// multi_reader_byte_ring_buffer_unit: byte ring buffer with absolute cursors
// Front classifier, command queue, store sequencer and result queue.
// ----------------------------------------------------------------------------
// A byte ring buffer addressed by absolute 32-bit stream cursors, so several
// readers can each keep their own position. Requests enter through a queue
// style port (push/full) and results leave through one (empty/pop). A write
// or clear gives one result; a read gives one result per byte returned (one
// result when it returns nothing or the cursor is invalid). Each result takes
// one turn of the back end, which drives the single port of the byte store and
// serves one read or one write per cycle while the result queue has room.
// Cursor checks and head/fill updates happen when the request is taken, so
// writes keep flowing while a read is still being unrolled, until the
// four-entry command queue between the two fills up. The store needs no
// clearing pass: the cursor rules never let a read reach a byte that was not
// written. Cursor wrap past 2^32 is not handled.
// ----------------------------------------------------------------------------
module multi_reader_byte_ring_buffer_unit import mrbrb_pkg::*; #(
  parameter int STORE_DEPTH  = STORE_DEPTH_DEF,
  parameter int MAX_READ_RUN = MAX_READ_RUN_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  in_t  request,
  output logic empty,
  input  logic pop,
  output out_t result
);

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CMD_W  = $bits(cmd_t) + 2 * ADDR_W;
  localparam int RES_W  = $bits(out_t);

  // front -> command queue
  logic              cmd_push;
  cmd_t              cmd_in;
  logic [ADDR_W-1:0] diff_in;
  logic [ADDR_W-1:0] head_addr_in;

  // command queue -> back
  logic [CMD_W-1:0]  cmd_q;
  logic              cmd_empty;
  logic              cmd_pop;
  cmd_t              cmd_out;
  logic [ADDR_W-1:0] diff_out;
  logic [ADDR_W-1:0] head_addr_out;

  // back -> result queue
  logic              res_push;
  out_t              res_data;
  logic              res_full;
  logic [RES_W-1:0]  res_q;

  // Front end: takes a request whenever the command queue has a slot.
  mrbrb_front #(
    .STORE_DEPTH  (STORE_DEPTH),
    .MAX_READ_RUN (MAX_READ_RUN)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (push),
    .req           (request),
    .room          (!full),
    .cmd_push      (cmd_push),
    .cmd           (cmd_in),
    .cmd_diff      (diff_in),
    .cmd_head_addr (head_addr_in)
  );

  mrbrb_queue #(
    .WIDTH   (CMD_W),
    .DEPTH   (QUEUE_DEPTH),
    .RESERVE (0)
  ) u_cmd_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data ({cmd_in, diff_in, head_addr_in}),
    .full      (full),
    .pop       (cmd_pop),
    .pop_data  (cmd_q),
    .empty     (cmd_empty)
  );

  assign {cmd_out, diff_out, head_addr_out} = cmd_q;

  // Back end: one store access per cycle; issues only while the result
  // queue can still take what is already in flight plus this transfer.
  mrbrb_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (!cmd_empty),
    .cmd           (cmd_out),
    .cmd_diff      (diff_out),
    .cmd_head_addr (head_addr_out),
    .cmd_pop       (cmd_pop),
    .res_room      (!res_full),
    .res_push      (res_push),
    .res_data      (res_data)
  );

  // Result queue keeps one slot in reserve for the store read in flight.
  mrbrb_queue #(
    .WIDTH   (RES_W),
    .DEPTH   (QUEUE_DEPTH),
    .RESERVE (1)
  ) u_res_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_data),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (res_q),
    .empty     (empty)
  );

  assign result = res_q;

endmodule

@@ hw/rtl/mrbrb_queue.sv @@
// ----------------------------------------------------------------------------
// mrbrb_queue: small register queue
// First-in first-out buffer; full can be raised early to keep slots in reserve.
// ----------------------------------------------------------------------------
module mrbrb_queue #(
  parameter int WIDTH   = 8,
  parameter int DEPTH   = 4,
  parameter int RESERVE = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign do_pop   = pop && !empty;
  assign empty    = (count == '0);
  assign full     = (count >= CNT_W'(DEPTH - RESERVE));
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

@@ hw/rtl/mrbrb_front.sv @@
// ----------------------------------------------------------------------------
// mrbrb_front: request classifier and cursor state
// Checks the cursor, updates head/fill, builds one command per request.
// ----------------------------------------------------------------------------
module mrbrb_front import mrbrb_pkg::*; #(
  parameter int STORE_DEPTH  = STORE_DEPTH_DEF,
  parameter int MAX_READ_RUN = MAX_READ_RUN_DEF,
  localparam int ADDR_W      = $clog2(STORE_DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  in_t               req,
  input  logic              room,
  output logic              cmd_push,
  output cmd_t              cmd,
  output logic [ADDR_W-1:0] cmd_diff,
  output logic [ADDR_W-1:0] cmd_head_addr
);

  logic [CURSOR_W-1:0] head, head_next;
  logic [CURSOR_W-1:0] oldest, oldest_next;
  logic [ADDR_W-1:0]   held, held_next;
  logic [ADDR_W-1:0]   head_addr, head_addr_next;

  logic [CURSOR_W-1:0] diff;
  logic [ADDR_W-1:0]   diff_f;
  logic                in_range;
  logic                at_head;
  logic [READ_W-1:0]   run_a;
  logic [READ_W-1:0]   run_n;
  logic                post_ok;
  logic [ADDR_W-1:0]   after_f;
  logic [ADDR_W-1:0]   before_f;
  logic [CURSOR_W-1:0] after_w;
  logic [CURSOR_W-1:0] before_w;
  logic [CURSOR_W-1:0] fill_w;

  assign cmd_push      = req_valid && room;
  assign diff          = head - req.cursor;
  assign diff_f        = diff[ADDR_W-1:0];
  assign in_range      = (req.cursor <= head) && (diff <= CURSOR_W'(held));
  assign at_head       = (req.cursor == head);
  assign cmd_diff      = diff_f;
  assign cmd_head_addr = head_addr;

  // run length: min(bytes after cursor, requested, run limit)
  assign run_a = (diff < CURSOR_W'(req.read_length)) ? diff[READ_W-1:0] : req.read_length;
  assign run_n = (run_a > READ_W'(MAX_READ_RUN)) ? READ_W'(MAX_READ_RUN) : run_a;

  always_comb begin
    head_next      = head;
    oldest_next    = oldest;
    held_next      = held;
    head_addr_next = head_addr;
    post_ok        = in_range;
    after_f        = diff_f;
    cmd.kind       = KIND_NOTE;
    cmd.write_byte = req.write_byte;
    cmd.info.accepted   = 1'b0;
    cmd.info.byte_count = '0;
    case (req.operation)
      OP_READ: begin
        if (in_range) begin
          cmd.kind            = (run_n == '0) ? KIND_NOTE : KIND_READ;
          cmd.info.accepted   = 1'b1;
          cmd.info.byte_count = run_n;
        end
      end
      OP_WRITE: begin
        if (in_range) begin
          cmd.kind            = KIND_WRITE;
          cmd.info.accepted   = 1'b1;
          cmd.info.byte_count = READ_W'(1);
          if (at_head) begin
            head_next      = head + 1'b1;
            head_addr_next = (head_addr == ADDR_W'(STORE_DEPTH - 1)) ? '0
                                                                     : head_addr + 1'b1;
            after_f        = ADDR_W'(1);
            // full store: oldest byte drops out
            if (held == ADDR_W'(STORE_DEPTH - 1)) begin
              oldest_next = oldest + 1'b1;
            end else begin
              held_next = held + 1'b1;
            end
          end
        end
      end
      OP_CLEAR: begin
        head_next           = '0;
        oldest_next         = '0;
        held_next           = '0;
        head_addr_next      = '0;
        post_ok             = (req.cursor == '0);
        after_f             = '0;
        cmd.info.accepted   = 1'b1;
      end
      default: begin
      end
    endcase

    before_f = held_next - after_f;
    after_w  = post_ok ? CURSOR_W'(after_f) : '0;
    before_w = post_ok ? CURSOR_W'(before_f) : '0;
    fill_w   = CURSOR_W'(held_next);

    cmd.info.bytes_after     = after_w[LEVEL_W-1:0];
    cmd.info.bytes_before    = before_w[LEVEL_W-1:0];
    cmd.info.write_position  = head_next;
    cmd.info.oldest_position = oldest_next;
    cmd.info.fill_level      = fill_w[LEVEL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      oldest    <= '0;
      held      <= '0;
      head_addr <= '0;
    end else if (cmd_push) begin
      head      <= head_next;
      oldest    <= oldest_next;
      held      <= held_next;
      head_addr <= head_addr_next;
    end
  end

endmodule

@@ hw/rtl/mrbrb_back.sv @@
// ----------------------------------------------------------------------------
// mrbrb_back: store and result sequencer
// Runs commands in order against the byte store, one store access per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module mrbrb_back import mrbrb_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  localparam int ADDR_W     = $clog2(STORE_DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  input  logic [ADDR_W-1:0] cmd_diff,
  input  logic [ADDR_W-1:0] cmd_head_addr,
  output logic              cmd_pop,
  input  logic              res_room,
  output logic              res_push,
  output out_t              res_data
);

  logic [BYTE_W-1:0] store [STORE_DEPTH];
  logic [BYTE_W-1:0] rdata;

  logic              busy;
  logic [ADDR_W-1:0] cur_idx;
  logic [READ_W-1:0] cur_rem;
  info_t             cur_info;

  logic              pending;
  logic              pend_last;
  logic              pend_mem;
  info_t             pend_info;

  logic [ADDR_W:0]   idx_wide;
  logic [ADDR_W-1:0] new_idx;
  logic              act;
  logic              s_read;
  logic              s_write;
  logic [ADDR_W-1:0] s_idx;
  logic [ADDR_W-1:0] s_idx_inc;
  logic [READ_W-1:0] s_rem;
  info_t             s_info;

  // store index of the cursor: head index minus distance, modulo depth
  assign idx_wide = {1'b0, cmd_head_addr}
                  + ((cmd_head_addr < cmd_diff) ? (ADDR_W + 1)'(STORE_DEPTH) : '0)
                  - {1'b0, cmd_diff};
  assign new_idx  = idx_wide[ADDR_W-1:0];

  assign act       = (busy || cmd_valid) && res_room;
  assign cmd_pop   = act && !busy;
  assign s_read    = busy || (cmd.kind == KIND_READ);
  assign s_write   = !busy && (cmd.kind == KIND_WRITE);
  assign s_idx     = busy ? cur_idx : new_idx;
  assign s_rem     = busy ? cur_rem : cmd.info.byte_count;
  assign s_info    = busy ? cur_info : cmd.info;
  assign s_idx_inc = (s_idx == ADDR_W'(STORE_DEPTH - 1)) ? '0 : s_idx + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      pending <= 1'b0;
    end else begin
      pending <= act;
      if (act) begin
        busy <= s_read && (s_rem != READ_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (act) begin
      cur_idx   <= s_idx_inc;
      cur_rem   <= s_rem - 1'b1;
      cur_info  <= s_info;
      pend_info <= s_info;
      pend_last <= !s_read || (s_rem == READ_W'(1));
      pend_mem  <= s_read;
    end
  end

  always_ff @(posedge clk) begin
    if (act && s_write) begin
      store[s_idx] <= cmd.write_byte;
    end
    if (act && s_read) begin
      rdata <= store[s_idx];
    end
  end

  assign res_push                 = pending;
  assign res_data.read_byte       = pend_mem ? rdata : '0;
  assign res_data.last            = pend_last;
  assign res_data.accepted        = pend_info.accepted;
  assign res_data.byte_count      = pend_info.byte_count;
  assign res_data.bytes_after     = pend_info.bytes_after;
  assign res_data.bytes_before    = pend_info.bytes_before;
  assign res_data.write_position  = pend_info.write_position;
  assign res_data.oldest_position = pend_info.oldest_position;
  assign res_data.fill_level      = pend_info.fill_level;

endmodule

@@ hw/rtl/mrbrb_checker.sv @@
// ----------------------------------------------------------------------------
// mrbrb_checker: port-level checks of the ring buffer unit
// Watches result transfers and reset behavior; bound to the top level.
// ----------------------------------------------------------------------------
module mrbrb_checker import mrbrb_pkg::*; (
  input logic clk,
  input logic rst,
  input logic empty,
  input logic pop,
  input out_t result
);

  // nothing waits on the result side right after reset
  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("results visible after reset");

  // a stalled result holds still
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed");

  // a refused operation moves no bytes and ends at once
  a_refused_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.accepted) |->
      (result.byte_count == '0 && result.read_byte == '0 && result.last))
    else $error("refused operation reports data");

  // bytes before and after an accepted cursor add up to the fill
  a_split_sums: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.accepted) |->
      (LEVEL_W'(result.bytes_after + result.bytes_before) == result.fill_level))
    else $error("cursor split does not match fill");

  // an operation that moves no bytes gives exactly one result
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.byte_count == '0) |-> result.last)
    else $error("zero-byte operation not marked last");

endmodule

bind multi_reader_byte_ring_buffer_unit mrbrb_checker u_checker (.*);

@@ test/tb_multi_reader_byte_ring_buffer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_reader_byte_ring_buffer_unit: self-checking bench for the ring unit
// Requests are queued up front and sent by a falling-edge driver. A rising-edge
// monitor runs every accepted request through a local ring predictor and
// checks each popped result against the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_multi_reader_byte_ring_buffer_unit;
  import mrbrb_pkg::*;

  localparam int RING_DEPTH   = STORE_DEPTH_DEF;
  localparam int RUN_LIMIT    = MAX_READ_RUN_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;  // code the block must ignore
  localparam int IDLE_PCT     = 30;
  localparam int QUIET_FROM   = 300;             // cycles with no idling on
  localparam int QUIET_TO     = 700;             // either side
  localparam int RANDOM_ITEMS = 200;
  localparam int FILL_WRITES  = 240;             // head writes in the closing stream
  localparam int DRAIN_CYCLES = 20;
  localparam int SHOW_LIMIT   = 10;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic push  = 1'b0;
  logic pop   = 1'b0;
  in_t  request = '0;
  logic full;
  logic empty;
  out_t result;

  // stimulus side
  in_t         request_q[$];
  logic [31:0] plan_head = '0;  // head/fill as the generator sees them,
  logic [31:0] plan_fill = '0;  // only used to aim cursors
  int          made_count = 0;

  // predictor state
  logic [BYTE_W-1:0] ring_bytes [RING_DEPTH];
  logic [31:0]       ring_head = '0;
  logic [31:0]       ring_fill = '0;
  out_t              pending_results[$];

  bit          took_request = 1'b0;
  int          taken_count  = 0;
  int          fail_count   = 0;
  int unsigned cycle_no     = 0;

  multi_reader_byte_ring_buffer_unit #(
    .STORE_DEPTH (RING_DEPTH),
    .MAX_READ_RUN(RUN_LIMIT)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .request(request),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // reset starts high and is released on a falling edge
  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Ring predictor
  // --------------------------------------------------------------------------

  // A cursor may be used when it sits between the oldest byte and the head.
  function automatic bit in_window(input logic [31:0] c);
    return (c <= ring_head) && ((ring_head - c) <= ring_fill);
  endfunction

  // Status fields shared by every result, taken from the state after the
  // operation; the window fields read zero for a cursor outside the window.
  function automatic out_t ring_status(input logic [31:0] c, input logic [BYTE_W-1:0] b,
                                       input logic lst, input logic acc,
                                       input logic [READ_W-1:0] cnt);
    out_t        r;
    logic [31:0] ahead;
    logic [31:0] behind;
    r = '0;
    r.read_byte  = b;
    r.last       = lst;
    r.accepted   = acc;
    r.byte_count = cnt;
    if (in_window(c)) begin
      ahead          = ring_head - c;
      behind         = ring_fill - ahead;
      r.bytes_after  = ahead[LEVEL_W-1:0];
      r.bytes_before = behind[LEVEL_W-1:0];
    end
    r.write_position  = ring_head;
    r.oldest_position = ring_head - ring_fill;
    r.fill_level      = ring_fill[LEVEL_W-1:0];
    return r;
  endfunction

  task automatic ring_step(input in_t rq);
    logic [31:0] c;
    logic [31:0] run;
    logic [31:0] addr;
    logic [31:0] next_head;
    c = rq.cursor;
    case (rq.operation)
      OP_READ: begin
        if (!in_window(c)) begin
          pending_results.push_back(ring_status(c, '0, 1'b1, 1'b0, '0));
        end else begin
          // run is clipped by the data ahead, the request and the run limit
          run = ring_head - c;
          if (run > rq.read_length) run = rq.read_length;
          if (run > RUN_LIMIT) run = RUN_LIMIT;
          if (run == 0) begin
            pending_results.push_back(ring_status(c, '0, 1'b1, 1'b1, '0));
          end else begin
            for (int k = 0; k < run; k++) begin
              addr = c + k;
              pending_results.push_back(ring_status(c, ring_bytes[addr % RING_DEPTH],
                                                    (k + 1 == run), 1'b1,
                                                    run[READ_W-1:0]));
            end
          end
        end
      end
      OP_WRITE: begin
        if (!in_window(c)) begin
          pending_results.push_back(ring_status(c, '0, 1'b1, 1'b0, '0));
        end else begin
          ring_bytes[c % RING_DEPTH] = rq.write_byte;
          next_head = c + 32'd1;
          if (ring_head < next_head) begin
            ring_fill = ring_fill + (next_head - ring_head);
            ring_head = next_head;
          end
          // oldest byte drops out once the ring is full
          if (ring_fill >= RING_DEPTH) ring_fill = RING_DEPTH - 1;
          pending_results.push_back(ring_status(c, '0, 1'b1, 1'b1, 7'd1));
        end
      end
      OP_CLEAR: begin
        ring_head = '0;
        ring_fill = '0;
        pending_results.push_back(ring_status(c, '0, 1'b1, 1'b1, '0));
      end
      default: begin
        pending_results.push_back(ring_status(c, '0, 1'b1, 1'b0, '0));
      end
    endcase
  endtask

  function automatic string result_text(input out_t r);
    return $sformatf({"byte=%02h last=%0b acc=%0b count=%0d after=%0d before=%0d",
                      " wr=%08h old=%08h fill=%0d"},
                     r.read_byte, r.last, r.accepted, r.byte_count, r.bytes_after,
                     r.bytes_before, r.write_position, r.oldest_position, r.fill_level);
  endfunction

  task automatic check_result(input out_t got);
    out_t want;
    if (pending_results.size() == 0) begin
      fail_count++;
      if (fail_count <= SHOW_LIMIT) $display("unexpected result: %s", result_text(got));
    end else begin
      want = pending_results.pop_front();
      if (got.read_byte !== want.read_byte || got.last !== want.last ||
          got.accepted !== want.accepted || got.byte_count !== want.byte_count ||
          got.bytes_after !== want.bytes_after || got.bytes_before !== want.bytes_before ||
          got.write_position !== want.write_position ||
          got.oldest_position !== want.oldest_position ||
          got.fill_level !== want.fill_level) begin
        fail_count++;
        if (fail_count <= SHOW_LIMIT) begin
          $display("result mismatch at cycle %0d", cycle_no);
          $display("  expected %s", result_text(want));
          $display("  actual   %s", result_text(got));
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus generation
  // --------------------------------------------------------------------------

  task automatic plan_request(input logic [OP_W-1:0] op, input logic [31:0] c,
                              input logic [BYTE_W-1:0] wb, input logic [READ_W-1:0] len);
    in_t rq;
    rq.operation   = op;
    rq.cursor      = c;
    rq.write_byte  = wb;
    rq.read_length = len;
    request_q.push_back(rq);
    // only a write at the head moves it; clear resets everything
    if (op == OP_WRITE && c == plan_head) begin
      plan_head = plan_head + 1;
      if (plan_fill < RING_DEPTH - 1) plan_fill = plan_fill + 1;
    end else if (op == OP_CLEAR) begin
      plan_head = '0;
      plan_fill = '0;
    end
  endtask

  function automatic logic [31:0] any_valid_cursor();
    return plan_head - $urandom_range(plan_fill, 0);
  endfunction

  // just past the head, just before the oldest byte, or anywhere at all
  function automatic logic [31:0] bad_cursor();
    logic [31:0] c;
    case ($urandom_range(2, 0))
      0:       c = plan_head + 1 + $urandom_range(40, 0);
      1:       c = (plan_head > plan_fill) ? plan_head - plan_fill - 1 : $urandom;
      default: c = $urandom;
    endcase
    while (c <= plan_head && (plan_head - c) <= plan_fill) c = $urandom;
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: one assignment per signal per falling edge; a request stays up
  // until its transfer has happened.
  // --------------------------------------------------------------------------

  function automatic bit idle_now();
    if (cycle_no >= QUIET_FROM && cycle_no < QUIET_TO) return 1'b0;
    return ($urandom_range(99, 0) < IDLE_PCT);
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
      pop  <= 1'b0;
    end else begin
      if (!push || took_request) begin
        if (request_q.size() != 0 && !idle_now()) begin
          request <= request_q.pop_front();
          push    <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
      pop <= !idle_now();
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on each request transfer, check on each result transfer.
  // Outputs are read before the block's own updates at this edge land.
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    cycle_no++;
    took_request = 1'b0;
    if (!rst) begin
      if (push && !full) begin
        took_request = 1'b1;
        ring_step(request);
        taken_count++;
      end
      if (pop && !empty) check_result(result);
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------

  initial begin
    int          pick;
    int          counted;
    logic [7:0]  wb;
    logic [6:0]  len;

    // directed: empty buffer, short stream, clipping, rejects, clear
    plan_request(OP_READ,  32'd0,          8'hFF, 7'd64);  // valid but nothing ahead
    plan_request(OP_WRITE, 32'd1,          8'h00, 7'd64);  // above head: rejected
    plan_request(OP_WRITE, 32'd0,          8'h00, 7'd0);
    plan_request(OP_WRITE, 32'd1,          8'hFF, 7'd64);
    plan_request(OP_WRITE, 32'd2,          8'hA5, 7'd1);
    plan_request(OP_WRITE, 32'd3,          8'h5A, 7'd33);
    plan_request(OP_READ,  32'd0,          8'h00, 7'd64);  // clipped to data ahead
    plan_request(OP_READ,  32'd1,          8'hFF, 7'd2);   // clipped to request
    plan_request(OP_READ,  32'd4,          8'h12, 7'd10);  // at head: empty read
    plan_request(OP_READ,  32'd0,          8'h34, 7'd0);   // zero length
    plan_request(OP_WRITE, 32'd1,          8'h3C, 7'd0);   // overwrite below head
    plan_request(OP_READ,  32'd0,          8'h00, 7'd64);
    plan_request(OP_READ,  32'hFFFF_FFFF,  8'hFF, 7'd64);  // far outside window
    plan_request(OP_WRITE, 32'h8000_0000,  8'hFF, 7'd64);
    plan_request(OP_READ,  32'd5,          8'h00, 7'd1);   // just past head
    plan_request(OP_UNUSED, 32'd0,         8'hFF, 7'd64);
    plan_request(OP_UNUSED, 32'hFFFF_FFFF, 8'h00, 7'd0);
    plan_request(OP_CLEAR, 32'd2,          8'h00, 7'd5);   // window fields vs cleared state
    plan_request(OP_READ,  32'd0,          8'h00, 7'd5);
    plan_request(OP_READ,  32'd1,          8'h00, 7'd5);
    plan_request(OP_WRITE, 32'd0,          8'h77, 7'd0);
    plan_request(OP_READ,  32'd0,          8'h00, 7'd1);
    plan_request(OP_CLEAR, 32'hFFFF_FFFF,  8'hFF, 7'd64);

    // random mix, mostly a live stream with readers at random positions;
    // ignored codes are sent but not counted
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(99, 0);
      wb   = 8'($urandom_range(255, 0));
      len  = 7'($urandom_range(64, 0));
      if (pick < 40) begin
        plan_request(OP_WRITE, plan_head, wb, len);
      end else if (pick < 65) begin
        plan_request(OP_READ, any_valid_cursor(), wb, len);
      end else if (pick < 73) begin
        plan_request(OP_WRITE, any_valid_cursor(), wb, len);
      end else if (pick < 76) begin
        plan_request(OP_CLEAR, $urandom_range(1, 0) ? 32'd0 : $urandom, wb, len);
      end else if (pick < 90) begin
        plan_request(pick[0] ? OP_READ : OP_WRITE, bad_cursor(), wb, len);
      end else if (pick < 93) begin
        plan_request(OP_UNUSED, $urandom, wb, len);
      end else begin
        plan_request(OP_READ, plan_head - plan_fill, wb, 7'd64);
      end
      if (pick < 90 || pick >= 93) counted++;
    end

    // stream of head writes from a cleared ring; readers poke at both ends
    // of the window now and then
    plan_request(OP_CLEAR, 32'd0, 8'h00, 7'd0);
    for (int i = 0; i < FILL_WRITES; i++) begin
      plan_request(OP_WRITE, plan_head, 8'($urandom_range(255, 0)),
                   7'($urandom_range(64, 0)));
      if (i % 97 == 96) begin
        plan_request(OP_READ,  plan_head - plan_fill, 8'($urandom_range(255, 0)), 7'd64);
        plan_request(OP_READ,  bad_cursor(),          8'($urandom_range(255, 0)), 7'd64);
        plan_request(OP_WRITE, plan_head - plan_fill, 8'($urandom_range(255, 0)), 7'd0);
        plan_request(OP_WRITE, bad_cursor(),          8'($urandom_range(255, 0)), 7'd0);
        plan_request(OP_READ,  any_valid_cursor(),    8'($urandom_range(255, 0)),
                     7'($urandom_range(64, 0)));
      end
    end
    made_count = request_q.size();

    // every request transferred, every result back, then a short drain
    while (taken_count != made_count) @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #6_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
